@@ rtl/core/plf_pkg.sv @@
package plf_pkg;

  localparam int unsigned LetterW = 5;
  localparam int unsigned Letters = 26;
  localparam int unsigned Cells   = 25;
  localparam int unsigned Side    = 5;
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

  typedef logic [LetterW-1:0] letter_t;

  localparam letter_t LetI = letter_t'(8);
  localparam letter_t LetJ = letter_t'(9);
  localparam letter_t LetZ = letter_t'(25);

  typedef enum logic [1:0] {
    ACT_KEY   = 2'd0,
    ACT_CLOSE = 2'd1,
    ACT_TEXT  = 2'd2,
    ACT_END   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CMD_PLACE = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_PAIR  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e kind;
    letter_t   a;
    letter_t   b;
  } cmd_t;

endpackage

@@ rtl/core/plf_ifs.sv @@
interface plf_in_if;
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  plf_pkg::letter_t letter;

  modport source (output valid, action, letter, input ready);
  modport sink (input valid, action, letter, output ready);
endinterface

interface plf_out_if;
  logic             valid;
  logic             ready;
  plf_pkg::letter_t cipher_letter;
  logic             pair_last;

  modport source (output valid, cipher_letter, pair_last, input ready);
  modport sink (input valid, cipher_letter, pair_last, output ready);
endinterface

@@ rtl/core/plf_front.sv @@
module plf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  plf_in_if.sink        item_i,
  output plf_pkg::cmd_t cmd_o,
  output logic          cmd_push_o,
  input  logic          cmd_ready_i
);

  logic                          closed_q, closed_d;
  logic [plf_pkg::Letters-1:0]   used_q, used_d;
  plf_pkg::letter_t              held_q, held_d;
  logic                          held_valid_q, held_valid_d;

  logic             accept;
  logic             letter_ok;
  logic             push;
  plf_pkg::letter_t text_let;

  assign item_i.ready = cmd_ready_i;
  assign accept       = item_i.valid && cmd_ready_i;
  assign letter_ok    = item_i.letter < plf_pkg::LetterW'(plf_pkg::Letters);
  assign text_let     = (item_i.letter == plf_pkg::LetJ) ? plf_pkg::LetI : item_i.letter;

  always_comb begin
    closed_d     = closed_q;
    used_d       = used_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    push         = 1'b0;
    cmd_o.kind   = plf_pkg::CMD_PLACE;
    cmd_o.a      = item_i.letter;
    cmd_o.b      = plf_pkg::LetZ;
    case (plf_pkg::action_e'(item_i.action))
      plf_pkg::ACT_KEY: begin
        // Repeated keyword letters are dropped here, so the back end only sees new ones.
        if (!closed_q && letter_ok && item_i.letter != plf_pkg::LetJ &&
            !used_q[item_i.letter]) begin
          push = 1'b1;
          if (accept) begin
            used_d[item_i.letter] = 1'b1;
          end
        end
      end
      plf_pkg::ACT_CLOSE: begin
        if (!closed_q) begin
          push       = 1'b1;
          cmd_o.kind = plf_pkg::CMD_CLOSE;
          if (accept) begin
            closed_d = 1'b1;
          end
        end
      end
      plf_pkg::ACT_TEXT: begin
        if (closed_q && letter_ok) begin
          if (!held_valid_q) begin
            if (accept) begin
              held_d       = text_let;
              held_valid_d = 1'b1;
            end
          end else begin
            push       = 1'b1;
            cmd_o.kind = plf_pkg::CMD_PAIR;
            cmd_o.a    = held_q;
            cmd_o.b    = (text_let == held_q) ? plf_pkg::LetZ : text_let;
            if (accept) begin
              held_valid_d = 1'b0;
            end
          end
        end
      end
      plf_pkg::ACT_END: begin
        if (closed_q && held_valid_q) begin
          push       = 1'b1;
          cmd_o.kind = plf_pkg::CMD_PAIR;
          cmd_o.a    = held_q;
          cmd_o.b    = plf_pkg::LetZ;
          if (accept) begin
            held_valid_d = 1'b0;
          end
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign cmd_push_o = accept && push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_q     <= 1'b0;
      used_q       <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
    end else begin
      closed_q     <= closed_d;
      used_q       <= used_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
    end
  end

endmodule

@@ rtl/core/plf_cmd_fifo.sv @@
module plf_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  plf_pkg::cmd_t cmd_i,
  output logic          ready_o,
  output logic          valid_o,
  output plf_pkg::cmd_t cmd_o,
  input  logic          pop_i
);

  plf_pkg::cmd_t                  slot_q [plf_pkg::CmdDepth];
  logic [plf_pkg::CmdPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [plf_pkg::CmdCntW-1:0]    count_q;
  logic                           do_push, do_pop;

  localparam logic [plf_pkg::CmdPtrW-1:0] LastPtr = plf_pkg::CmdPtrW'(plf_pkg::CmdDepth - 1);

  assign ready_o = count_q != plf_pkg::CmdCntW'(plf_pkg::CmdDepth);
  assign valid_o = count_q != '0;
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/plf_back.sv @@
module plf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  plf_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  plf_out_if.source     result_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FILL = 5'b00010,
    S_LOOK = 5'b00100,
    S_OUT0 = 5'b01000,
    S_OUT1 = 5'b10000
  } state_e;

  state_e                        state_q, state_d;
  plf_pkg::letter_t              fill_q, fill_d;
  logic [plf_pkg::Letters-1:0]   used_q, used_d;
  plf_pkg::letter_t              walk_q, walk_d;

  // Key square (cell to letter) and its inverse (letter to cell).
  plf_pkg::letter_t square_mem [plf_pkg::Cells];
  plf_pkg::letter_t place_mem  [plf_pkg::Letters];
  plf_pkg::letter_t place_a_q, place_b_q;
  plf_pkg::letter_t sq_a_q, sq_b_q;

  logic             wr_req, wr_en;
  plf_pkg::letter_t wr_let;
  logic             place_rd_en, sq_rd_en;
  plf_pkg::letter_t cell_a, cell_b;

  function automatic logic [2:0] row_of(plf_pkg::letter_t p);
    logic [8:0] prod;
    // For cell numbers below 25, (p * 13) >> 6 equals p / 5.
    prod = {4'b0, p} * 9'd13;
    return prod[8:6];
  endfunction

  function automatic logic [2:0] col_of(plf_pkg::letter_t p);
    logic [4:0] base;
    base = {2'b0, row_of(p)} * 5'd5;
    return 3'(p - base);
  endfunction

  function automatic logic [2:0] step_of(logic [2:0] v);
    return (v == 3'(plf_pkg::Side - 1)) ? 3'd0 : v + 3'd1;
  endfunction

  function automatic plf_pkg::letter_t cell_of(logic [2:0] r, logic [2:0] c);
    return ({2'b0, r} * 5'(plf_pkg::Side)) + {2'b0, c};
  endfunction

  always_comb begin
    logic [2:0] ra, ca, rb, cb;
    ra = row_of(place_a_q);
    ca = col_of(place_a_q);
    rb = row_of(place_b_q);
    cb = col_of(place_b_q);
    if (ra == rb) begin
      cell_a = cell_of(ra, step_of(ca));
      cell_b = cell_of(rb, step_of(cb));
    end else if (ca == cb) begin
      cell_a = cell_of(step_of(ra), ca);
      cell_b = cell_of(step_of(rb), cb);
    end else begin
      cell_a = cell_of(ra, cb);
      cell_b = cell_of(rb, ca);
    end
  end

  always_comb begin
    state_d     = state_q;
    walk_d      = walk_q;
    wr_req      = 1'b0;
    wr_let      = cmd_i.a;
    place_rd_en = 1'b0;
    sq_rd_en    = 1'b0;
    cmd_pop_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            plf_pkg::CMD_PLACE: begin
              wr_req = 1'b1;
            end
            plf_pkg::CMD_CLOSE: begin
              walk_d  = '0;
              state_d = S_FILL;
            end
            plf_pkg::CMD_PAIR: begin
              place_rd_en = 1'b1;
              state_d     = S_LOOK;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_FILL: begin
        // One letter of the alphabet is checked per cycle.
        wr_let = walk_q;
        wr_req = (walk_q != plf_pkg::LetJ) && !used_q[walk_q];
        walk_d = walk_q + 1'b1;
        if (walk_q == plf_pkg::LetterW'(plf_pkg::Letters - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_LOOK: begin
        sq_rd_en = 1'b1;
        state_d  = S_OUT0;
      end
      S_OUT0: begin
        if (result_o.ready) begin
          state_d = S_OUT1;
        end
      end
      S_OUT1: begin
        if (result_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign wr_en = wr_req && (fill_q < plf_pkg::LetterW'(plf_pkg::Cells));

  always_comb begin
    fill_d = fill_q;
    used_d = used_q;
    if (wr_en) begin
      fill_d         = fill_q + 1'b1;
      used_d[wr_let] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      square_mem[fill_q] <= wr_let;
      place_mem[wr_let]  <= fill_q;
    end
    if (place_rd_en) begin
      place_a_q <= place_mem[cmd_i.a];
      place_b_q <= place_mem[cmd_i.b];
    end
    if (sq_rd_en) begin
      sq_a_q <= square_mem[cell_a];
      sq_b_q <= square_mem[cell_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      used_q  <= '0;
      walk_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      used_q  <= used_d;
      walk_q  <= walk_d;
    end
  end

  assign result_o.valid         = (state_q == S_OUT0) || (state_q == S_OUT1);
  assign result_o.cipher_letter = (state_q == S_OUT1) ? sq_b_q : sq_a_q;
  assign result_o.pair_last     = (state_q == S_OUT1);

endmodule

@@ rtl/core/playfair_digraph_encryptor.sv @@
// Keyword and plaintext letters are taken one per cycle while the command queue has room.
// The first cipher letter of a pair is valid once its second letter has gone through the
// command queue, place lookup and square lookup; the second follows once the first is taken.
// The back end takes one pair at a time and walks the alphabet, one letter per cycle, on a close.
// Reset is asynchronous and active low; it clears control state, the square memories are not
// cleared and are rebuilt from the next key.
module playfair_digraph_encryptor (
  input  logic      clk_i,
  input  logic      rst_ni,
  plf_in_if.sink    item_i,
  plf_out_if.source result_o
);

  plf_pkg::cmd_t front_cmd, back_cmd;
  logic          front_push, fifo_ready, fifo_valid, back_pop;

  plf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cmd_o       (front_cmd),
    .cmd_push_o  (front_push),
    .cmd_ready_i (fifo_ready)
  );

  plf_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .cmd_i   (front_cmd),
    .ready_o (fifo_ready),
    .valid_o (fifo_valid),
    .cmd_o   (back_cmd),
    .pop_i   (back_pop)
  );

  plf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (fifo_valid),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (back_pop),
    .result_o    (result_o)
  );

endmodule

@@ rtl/core/plf_checker.sv @@
module plf_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input plf_pkg::letter_t res_letter_i,
  input logic             res_last_i
);

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_letter_i) && $stable(res_last_i))
    else $error("result changed while stalled");

  // The second letter of a pair follows right after the first one is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && !res_last_i |=> res_valid_i && res_last_i)
    else $error("second letter of pair missing");

  // A new pair never starts in the cycle after a pair ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && res_last_i |=> !res_valid_i)
    else $error("pair started without lookup");

  // The square never holds j, and every cell holds a letter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_letter_i != plf_pkg::LetJ && res_letter_i <= plf_pkg::LetZ)
    else $error("cipher letter out of the square alphabet");

endmodule

bind playfair_digraph_encryptor plf_checker u_plf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (result_o.valid),
  .res_ready_i  (result_o.ready),
  .res_letter_i (result_o.cipher_letter),
  .res_last_i   (result_o.pair_last)
);
